### rtl/kvt_pkg.sv
// kvt_pkg: operation codes and shared constants for the key/value table.
// No dependencies; imported by the request interface and every module of the block.
package kvt_pkg;

  localparam int FUNC_WIDTH = 3;

  localparam logic [FUNC_WIDTH-1:0] FUNC_PUT      = 3'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_REPLACE  = 3'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_CONTAINS = 3'd2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_GET      = 3'd3;
  localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE   = 3'd4;
  localparam logic [FUNC_WIDTH-1:0] FUNC_LENGTH   = 3'd5;

endpackage

### rtl/kvt_ifs.sv
// kvt_ifs: valid/ready channel interfaces for requests and responses.
// Depends on kvt_pkg for the operation code width.
interface kvt_req_if import kvt_pkg::*; #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [FUNC_WIDTH-1:0]  func;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

interface kvt_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [VALUE_WIDTH-1:0] found_value;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, ok, found_value, entry_count, input ready);
  modport sink   (input valid, ok, found_value, entry_count, output ready);
endinterface

### rtl/kvt_store.sv
// kvt_store: key and value entry memories, one write and one registered read port.
// Imports kvt_pkg only by convention; nothing from it is used.
module kvt_store import kvt_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 4
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [KEY_WIDTH-1:0]   wr_key,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [AW-1:0]          rd_addr,
  output logic [KEY_WIDTH-1:0]   rd_key,
  output logic [VALUE_WIDTH-1:0] rd_value
);

  logic [KEY_WIDTH-1:0]   key_mem   [DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [KEY_WIDTH-1:0]   rd_key_r;
  logic [VALUE_WIDTH-1:0] rd_value_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r   <= key_mem[rd_addr];
    rd_value_r <= value_mem[rd_addr];
  end

  assign rd_key   = rd_key_r;
  assign rd_value = rd_value_r;

endmodule

### rtl/kvt_ctrl.sv
// kvt_ctrl: request sequencer; scans entries through one shared key comparator,
// shifts entries down on remove. Depends on kvt_pkg and kvt_req_if.
module kvt_ctrl import kvt_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  kvt_req_if.sink                req,
  output logic                   res_valid,
  input  logic                   res_free,
  output logic                   res_ok,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic [CW-1:0]          res_count,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [KEY_WIDTH-1:0]   wr_key,
  output logic [VALUE_WIDTH-1:0] wr_value,
  output logic [AW-1:0]          rd_addr,
  input  logic [KEY_WIDTH-1:0]   rd_key,
  input  logic [VALUE_WIDTH-1:0] rd_value
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_SH_RD = 3'd3;
  localparam logic [2:0] ST_SH_WR = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [FUNC_WIDTH-1:0]  func_r, func_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ok_r, ok_nxt;
  logic [VALUE_WIDTH-1:0] found_r, found_nxt;
  logic [CW-1:0]          idx_inc;
  logic                   shift_more;
  logic                   key_hit;

  assign idx_inc    = idx_r + CW'(1);
  assign shift_more = ({1'b0, idx_inc} + (CW+1)'(1)) < {1'b0, count_r};
  assign key_hit    = (rd_key == key_r);

  assign req.ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res_ok    = ok_r;
  assign res_value = found_r;
  assign res_count = count_r;

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    found_nxt = found_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_key    = key_r;
    wr_value  = value_r;
    rd_addr   = idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (req.valid) begin
          func_nxt  = req.func;
          key_nxt   = req.key;
          value_nxt = req.value;
          idx_nxt   = '0;
          ok_nxt    = 1'b0;
          found_nxt = '0;
          state_nxt = ST_RESP;
          case (req.func)
            FUNC_PUT: begin
              if (count_r != CW'(DEPTH)) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_key    = req.key;
                wr_value  = req.value;
                count_nxt = count_r + CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            FUNC_REPLACE, FUNC_CONTAINS, FUNC_GET, FUNC_REMOVE: begin
              if (count_r != '0) state_nxt = ST_RD;
            end
            FUNC_LENGTH: ok_nxt = (count_r != '0);
            default: ;
          endcase
        end
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (key_hit) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_RESP;
          case (func_r)
            FUNC_REPLACE: wr_en = 1'b1;
            FUNC_GET:     found_nxt = rd_value;
            FUNC_REMOVE: begin
              if (idx_inc < count_r) begin
                state_nxt = ST_SH_RD;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: ;
          endcase
        end else if (idx_inc == count_r) begin
          state_nxt = ST_RESP;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_RD;
        end
      end
      ST_SH_RD: begin
        rd_addr   = idx_inc[AW-1:0];
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        wr_en    = 1'b1;
        wr_key   = rd_key;
        wr_value = rd_value;
        idx_nxt  = idx_inc;
        if (shift_more) begin
          state_nxt = ST_SH_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    key_r   <= key_nxt;
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
    ok_r    <= ok_nxt;
    found_r <= found_nxt;
  end

endmodule

### rtl/key_value_table.sv
// key_value_table: top level; sequencer, entry store and response register.
// Depends on kvt_pkg, kvt_ifs, kvt_store and kvt_ctrl.
//
// Use: requests arrive on in_if (func, key, value) under valid/ready; one
// response per request leaves on out_if (ok, found_value, entry_count).
// Entries are kept in insertion order; searches take the first matching key.
// Sequence: put, length, unused codes and a search on an empty table go
// straight to the response; replace, contains and get read and compare one
// entry at a time (all entries on a miss); remove searches likewise, then
// reads and rewrites each later entry one slot down to close the gap.
// The sequencer returns to idle as the response is loaded into the output
// register and only then takes the next request. The pace is set by the
// single read port of the entry memory and the one key comparator, worst
// for a remove, or a search reaching the last entry, on a full table.
// in_if.ready is high only while no request is in work.
// Reset empties the table (count zero, no response pending); entry memory
// is not cleared. A stalled receiver holds the response in the output
// register; the next request may be taken meanwhile, and its response waits
// in the sequencer until the output register frees up.
module key_value_table import kvt_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kvt_req_if.sink   in_if,
  kvt_rsp_if.source out_if
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                   res_valid;
  logic                   res_free;
  logic                   res_ok;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [CW-1:0]          res_count;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [AW-1:0]          rd_addr;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ok_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic [CW-1:0]          out_count_r;
  logic                   out_load;

  kvt_ctrl #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_if),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res_ok    (res_ok),
    .res_value (res_value),
    .res_count (res_count),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_value  (wr_value),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_value  (rd_value)
  );

  kvt_store #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  assign res_free      = !out_valid_r || out_if.ready;
  assign out_load      = res_valid && res_free;
  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= res_ok;
      out_value_r <= res_value;
      out_count_r <= res_count;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.ok          = out_ok_r;
  assign out_if.found_value = out_value_r;
  assign out_if.entry_count = out_count_r;

endmodule

### tb/key_value_table_test.sv
// key_value_table_test: self-checking bench for key_value_table.
// Random valid/ready traffic is checked against an in-bench table predictor.
// Depends on kvt_pkg, kvt_ifs and the key_value_table RTL.
module key_value_table_test import kvt_pkg::*;;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 5;

  localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1400;
  localparam int HOLD_AT         = 250;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_FROM      = 600;
  localparam int QUIET_TO        = 900;
  localparam int SETTLE_CYCLES   = 4 * DEPTH + 16;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0]  func;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } kv_request_t;

  typedef struct packed {
    logic                   ok;
    logic [VALUE_WIDTH-1:0] found_value;
    logic [COUNT_WIDTH-1:0] entry_count;
  } kv_result_t;

  logic clk;
  logic rst_n;

  kvt_req_if #(.KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
  kvt_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp_ch ();

  key_value_table #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(req_ch),
    .out_if(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  kv_request_t pending_requests[$];
  kv_result_t  expected_results[$];

  logic [KEY_WIDTH-1:0]   kv_keys[DEPTH];
  logic [VALUE_WIDTH-1:0] kv_values[DEPTH];
  int kv_count = 0;

  int op_seen[8];
  int full_refusals = 0;
  int lookup_hits   = 0;
  int failures      = 0;
  int checked       = 0;
  int sent_count;
  int hold_left;
  logic hold_done;
  logic quiet;

  assign quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

  // table predictor: applies one request, returns the response it should cause
  function automatic kv_result_t apply_request(kv_request_t r);
    kv_result_t res;
    int hit;
    res = '0;
    hit = -1;
    for (int i = 0; i < kv_count; i++)
      if (hit < 0 && kv_keys[i] == r.key) hit = i;
    case (r.func)
      FUNC_PUT: begin
        if (kv_count < DEPTH) begin
          kv_keys[kv_count]   = r.key;
          kv_values[kv_count] = r.value;
          kv_count++;
          res.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      FUNC_REPLACE: begin
        if (hit >= 0) begin
          kv_values[hit] = r.value;
          res.ok = 1'b1;
        end
      end
      FUNC_CONTAINS: res.ok = (hit >= 0);
      FUNC_GET: begin
        if (hit >= 0) begin
          res.found_value = kv_values[hit];
          res.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i < kv_count - 1; i++) begin
            kv_keys[i]   = kv_keys[i + 1];
            kv_values[i] = kv_values[i + 1];
          end
          kv_count--;
          res.ok = 1'b1;
        end
      end
      FUNC_LENGTH: res.ok = (kv_count != 0);
      default: ;
    endcase
    if (hit >= 0 && r.func inside {FUNC_REPLACE, FUNC_CONTAINS, FUNC_GET, FUNC_REMOVE})
      lookup_hits++;
    res.entry_count = kv_count[COUNT_WIDTH-1:0];
    op_seen[r.func]++;
    return res;
  endfunction

  task automatic add_request(logic [FUNC_WIDTH-1:0] f, logic [KEY_WIDTH-1:0] k,
                             logic [VALUE_WIDTH-1:0] v);
    kv_request_t r;
    r.func  = f;
    r.key   = k;
    r.value = v;
    pending_requests.push_back(r);
  endtask

  initial begin
    logic [KEY_WIDTH-1:0] key_pool[6];
    logic [FUNC_WIDTH-1:0] f;
    logic [KEY_WIDTH-1:0] k;
    logic [VALUE_WIDTH-1:0] v;
    int roll;
    bit filling;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func  = '0;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    foreach (op_seen[i]) op_seen[i] = 0;

    // directed: empty table, spare codes, duplicates, full table, edge removes
    add_request(FUNC_LENGTH,   '0, '0);
    add_request(FUNC_GET,      '0, '0);
    add_request(FUNC_REMOVE,   '1, '0);
    add_request(FUNC_SPARE_6,  '1, '1);
    add_request(FUNC_SPARE_7,  '1, '1);
    add_request(FUNC_PUT,      '0, '1);
    add_request(FUNC_PUT,      '1, '0);
    add_request(FUNC_PUT,      '0, 32'd1);
    add_request(FUNC_GET,      '0, '0);
    add_request(FUNC_REPLACE,  '0, 32'd5);
    add_request(FUNC_CONTAINS, '1, '0);
    add_request(FUNC_CONTAINS, 32'h0000_1234, '0);
    add_request(FUNC_REMOVE,   '0, '0);
    add_request(FUNC_GET,      '0, '0);
    add_request(FUNC_REPLACE,  32'h0000_1234, 32'd9);
    for (int i = 0; i < DEPTH - 2; i++)
      add_request(FUNC_PUT, 32'hA5A5_0000 + i, $urandom);
    add_request(FUNC_PUT,      32'h5A5A_5A5A, '1);
    add_request(FUNC_GET,      32'hA5A5_0000 + DEPTH - 3, '0);
    add_request(FUNC_REMOVE,   '1, '0);
    add_request(FUNC_REMOVE,   32'hA5A5_0000 + DEPTH - 3, '0);
    add_request(FUNC_LENGTH,   '0, '0);

    // random: small key pool so searches hit; fill and drain phases alternate
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 6; i++) key_pool[i] = $urandom;
    filling = 1'b0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 120 == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < 4)       f = roll[0] ? FUNC_SPARE_7 : FUNC_SPARE_6;
      else if (roll < 8)  f = FUNC_LENGTH;
      else if (roll < 20) f = FUNC_REPLACE;
      else if (roll < 32) f = FUNC_CONTAINS;
      else if (roll < 50) f = FUNC_GET;
      else if (roll < (filling ? 85 : 60)) f = FUNC_PUT;
      else                f = FUNC_REMOVE;
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 5)] : $urandom;
      roll = $urandom_range(0, 99);
      v = (roll < 5) ? '0 : (roll < 10) ? '1 : $urandom;
      add_request(f, k, v);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests: put %0d, repl %0d, cont %0d, get %0d, rem %0d, len %0d, spare %0d",
             sent_count, op_seen[FUNC_PUT], op_seen[FUNC_REPLACE], op_seen[FUNC_CONTAINS],
             op_seen[FUNC_GET], op_seen[FUNC_REMOVE], op_seen[FUNC_LENGTH],
             op_seen[FUNC_SPARE_6] + op_seen[FUNC_SPARE_7]);
    $display("%0d responses checked, %0d search hits, %0d puts refused on a full table",
             checked, lookup_hits, full_refusals);
    if (failures == 0) begin
      $display("[key_value_table] OK");
    end else begin
      $display("[key_value_table] ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout: %0d requests outstanding", expected_results.size());
    $display("[key_value_table] ERROR");
    $finish;
  end

  // request driver; predicts each request as it is accepted
  always @(posedge clk) begin : driver
    kv_request_t next_req;
    kv_request_t taken;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      sent_count   <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        taken.func  = req_ch.func;
        taken.key   = req_ch.key;
        taken.value = req_ch.value;
        expected_results.push_back(apply_request(taken));
        sent_count <= sent_count + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= 29)) begin
          next_req = pending_requests.pop_front();
          req_ch.func  <= next_req.func;
          req_ch.key   <= next_req.key;
          req_ch.value <= next_req.value;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up onto its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    kv_result_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected response: ok=%0b value=%h count=%0d",
                     rsp_ch.ok, rsp_ch.found_value, rsp_ch.entry_count);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (rsp_ch.ok !== want.ok || rsp_ch.found_value !== want.found_value ||
              rsp_ch.entry_count !== want.entry_count) begin
            failures++;
            if (failures <= 10)
              $display("resp %0d: exp ok=%0b val=%h cnt=%0d, got ok=%0b val=%h cnt=%0d",
                       checked, want.ok, want.found_value, want.entry_count,
                       rsp_ch.ok, rsp_ch.found_value, rsp_ch.entry_count);
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 29);
    end
  end

endmodule
